/* rtl/dbba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbba_pkg: shared constants for the double buffer bump allocator
// Field widths, operation, pool, status and register index codes.
// ----------------------------------------------------------------------------
package dbba_pkg;

    localparam int CORE_W    = 5;
    localparam int BYTES_W   = 11;
    localparam int ADDR_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_HOST  = 1'b1;

    localparam logic POOL_CB  = 1'b0;
    localparam logic POOL_ACT = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_FAIL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CB_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_BASE = 1'b1;

endpackage : dbba_pkg
`default_nettype wire

/* rtl/dbba_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbba_if: valid/ready channels of the allocator
// Request, response and configuration write channels.
// ----------------------------------------------------------------------------
interface dbba_in_if
    import dbba_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               op;
    logic [CORE_W-1:0]  core;
    logic               pool;
    logic [BYTES_W-1:0] alloc_bytes;
    logic               ready_half;

    modport source (output valid, output op, output core, output pool,
                    output alloc_bytes, output ready_half, input ready);
    modport sink   (input valid, input op, input core, input pool,
                    input alloc_bytes, input ready_half, output ready);
endinterface : dbba_in_if

interface dbba_out_if
    import dbba_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              status;
    logic [ADDR_W-1:0] block_address;
    logic              half_used;

    modport source (output valid, output status, output block_address,
                    output half_used, input ready);
    modport sink   (input valid, input status, input block_address,
                    input half_used, output ready);
endinterface : dbba_out_if

interface dbba_cfg_if
    import dbba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface : dbba_cfg_if
`default_nettype wire

/* rtl/double_buffer_bump_allocator_top.sv */
// Flow: an accepted beat is held in stage 1, then in the result register.
// Throughput: one request per cycle unless rsp stalls; the state row RAM is read
// on accept, written back on commit, with a bypass for back-to-back row hits.
// Reset: region bases clear to zero; per-row valid bits clear so every row
// reads as writing half 0, ready half 1, counts 0. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_buffer_bump_allocator_top: ping-pong bump allocator
// Per core and pool, allocates bytes from two alternating halves.
// ----------------------------------------------------------------------------
module double_buffer_bump_allocator_top
    import dbba_pkg::*;
#(
    parameter int NUM_CORES  = 24,
    parameter int HALF_BYTES = 1024
)(
    input wire logic     clk,
    input wire logic     rst_n,
    dbba_in_if.sink      req,
    dbba_out_if.source   rsp,
    dbba_cfg_if.sink     cfg
);

    localparam int SLOTS = 2 * NUM_CORES;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(HALF_BYTES + 1);
    localparam int BW    = ((CW > BYTES_W) ? CW : BYTES_W) + 1;
    localparam int OW    = $clog2(SLOTS * HALF_BYTES) + 1;
    localparam int HW    = CORE_W + 1;
    localparam int RW    = 2 + 2 * CW;
    localparam int R_RDY = RW - 1;
    localparam int R_WR  = RW - 2;

    // row: ready half, writing half, count of half 1, count of half 0
    localparam logic [RW-1:0] ROW_RESET = {1'b1, {(RW-1){1'b0}}};

    logic [ADDR_W-1:0] cb_base_reg;
    logic [ADDR_W-1:0] act_base_reg;

    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic [CORE_W-1:0]  s1_core_reg;
    logic               s1_pool_reg;
    logic [BYTES_W-1:0] s1_bytes_reg;
    logic               s1_ready_half_reg;
    logic               s1_core_ok_reg;
    logic [SW-1:0]      s1_slot_reg;
    logic               s1_row_vld_reg;
    logic               s1_fwd_reg;
    logic [RW-1:0]      s1_fwd_row_reg;

    logic [SLOTS-1:0]   row_vld_reg;

    logic               rsp_valid_reg;
    logic               rsp_status_reg;
    logic [ADDR_W-1:0]  rsp_addr_reg;
    logic               rsp_half_reg;

    logic               req_fire;
    logic               advance;
    logic               commit;
    logic               core_ok;
    logic [SW-1:0]      rd_slot;
    logic [RW-1:0]      ram_rdata;
    logic               ram_we;

    logic [RW-1:0]      row_cur;
    logic [RW-1:0]      row_new;
    logic               cur_half;
    logic               rdy_half;
    logic [CW-1:0]      cnt_cur;
    logic [BW-1:0]      bytes_ext;
    logic [BW-1:0]      cnt_sum;
    logic               too_big;
    logic               fits;
    logic               new_half;
    logic [CW-1:0]      off_cnt;
    logic [CW-1:0]      cnt_val;
    logic [HW-1:0]      half_idx;
    logic [OW-1:0]      offset;
    logic [ADDR_W-1:0]  base;
    logic               we_c;
    logic               status_c;
    logic [ADDR_W-1:0]  addr_c;
    logic               half_c;

    // ---- configuration ----
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_base_reg  <= '0;
            act_base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.idx)
                CFG_CB_BASE:  cb_base_reg  <= cfg.data;
                CFG_ACT_BASE: act_base_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    // ---- handshake ----
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;
    assign commit    = s1_valid_reg && advance;
    assign ram_we    = commit && we_c;

    assign core_ok = int'(req.core) < NUM_CORES;
    assign rd_slot = SW'({req.core, req.pool});

    dbba_ram #(
        .WIDTH (RW),
        .DEPTH (SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_slot_reg),
        .wdata (row_new),
        .re    (req_fire),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    // ---- stage 1 control ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            row_vld_reg  <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                row_vld_reg[s1_slot_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_op_reg         <= req.op;
            s1_core_reg       <= req.core;
            s1_pool_reg       <= req.pool;
            s1_bytes_reg      <= req.alloc_bytes;
            s1_ready_half_reg <= req.ready_half;
            s1_core_ok_reg    <= core_ok;
            s1_slot_reg       <= rd_slot;
            s1_row_vld_reg    <= core_ok && row_vld_reg[rd_slot];
            s1_fwd_reg        <= ram_we && (s1_slot_reg == rd_slot);
            s1_fwd_row_reg    <= row_new;
        end
    end

    // ---- stage 1 datapath ----
    always_comb
    begin
        row_cur   = s1_fwd_reg ? s1_fwd_row_reg :
                    (s1_row_vld_reg ? ram_rdata : ROW_RESET);
        cur_half  = row_cur[R_WR];
        rdy_half  = row_cur[R_RDY];
        cnt_cur   = cur_half ? row_cur[2*CW-1:CW] : row_cur[CW-1:0];
        bytes_ext = BW'(s1_bytes_reg);
        too_big   = bytes_ext > BW'(HALF_BYTES);
        cnt_sum   = BW'(cnt_cur) + bytes_ext;
        fits      = cnt_sum <= BW'(HALF_BYTES);
        new_half  = fits ? cur_half : ~cur_half;
        off_cnt   = fits ? cnt_cur : '0;
        cnt_val   = fits ? CW'(cnt_sum) : CW'(s1_bytes_reg);
        half_idx  = {s1_core_reg, new_half};
        offset    = OW'(half_idx) * OW'(HALF_BYTES) + OW'(off_cnt);
        base      = (s1_pool_reg == POOL_ACT) ? act_base_reg : cb_base_reg;

        row_new   = row_cur;
        we_c      = 1'b0;
        status_c  = ST_OK;
        addr_c    = '0;
        half_c    = 1'b0;

        if (!s1_core_ok_reg)
        begin
            status_c = (s1_op_reg == OP_ALLOC) ? ST_FAIL : ST_OK;
        end
        else if (s1_op_reg == OP_HOST)
        begin
            row_new[R_RDY] = s1_ready_half_reg;
            we_c           = 1'b1;
        end
        else if (too_big || (!fits && (rdy_half == cur_half)))
        begin
            status_c = ST_FAIL;
        end
        else
        begin
            addr_c        = base + ADDR_W'(offset);
            half_c        = new_half;
            we_c          = 1'b1;
            row_new[R_WR] = new_half;
            if (new_half)
            begin
                row_new[2*CW-1:CW] = cnt_val;
            end
            else
            begin
                row_new[CW-1:0] = cnt_val;
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_status_reg <= status_c;
            rsp_addr_reg   <= addr_c;
            rsp_half_reg   <= half_c;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.block_address = rsp_addr_reg;
    assign rsp.half_used     = rsp_half_reg;

    // ---- assertions ----
    a_fail_no_addr : assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_FAIL) |-> (rsp.block_address == '0 && !rsp.half_used))
        else $error("refused beat carries an address");

    a_we_core_ok : assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (s1_core_ok_reg && s1_valid_reg))
        else $error("state write for an invalid core or empty stage");

    a_accept_fills : assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> s1_valid_reg)
        else $error("accepted beat lost before stage 1");

    a_fwd_row_vld : assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && ram_we && (s1_slot_reg == rd_slot)) |=> row_vld_reg[s1_slot_reg])
        else $error("bypassed row not marked valid");

endmodule : double_buffer_bump_allocator_top
`default_nettype wire

/* rtl/dbba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbba_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dbba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : dbba_ram
`default_nettype wire
